// ===== design/voice_allocator_with_stealing_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Short forms for the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_WITH_STEALING_CORE_ASSERT_SVH
`define VOICE_ALLOCATOR_WITH_STEALING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// The expression must hold at every clock edge outside reset.
`define VOA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("voice allocator check failed");

`endif

// ===== design/voa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Types, codes and constants shared by the voice cells and the top level.
// ----------------------------------------------------------------------------
package voa_pkg;

  localparam int unsigned MAX_VOICES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_VOICES);
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CHOSEN_W   = 4;
  localparam int unsigned KEY_W      = 7;
  localparam int unsigned NOTE_W     = 16;
  localparam int unsigned SCORE_W    = NOTE_W + 1;

  localparam logic [KEY_W-1:0]   PEDAL_DOWN_MIN = KEY_W'(64);
  // Stealing weight: higher score means lower priority (10000 - score).
  localparam logic [SCORE_W-1:0] REL_BONUS      = SCORE_W'(2000);
  localparam logic [SCORE_W-1:0] SUST_BONUS     = SCORE_W'(1000);

  typedef enum logic [2:0] {
    OP_NOTE_ON        = 3'd0,
    OP_NOTE_OFF       = 3'd1,
    OP_SUSTAIN        = 3'd2,
    OP_ALL_NOTES_OFF  = 3'd3,
    OP_ALL_SOUNDS_OFF = 3'd4,
    OP_VOICE_FINISHED = 3'd5
  } voa_op_e;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_HELD = 2'd1,
    ST_SUST = 2'd2,
    ST_REL  = 2'd3
  } voa_status_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [KEY_W-1:0] note_key;
    logic [KEY_W-1:0] pedal_value;
    logic [3:0]       finished_voice;
  } voa_in_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_voice;
    logic                was_stolen;
    logic                granted;
    logic [CNT_W-1:0]    matched_voices;
  } voa_out_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic [2:0]        op;
    logic [KEY_W-1:0]  key;
    logic [3:0]        fin;
    logic              pedal_down;
    logic [NOTE_W-1:0] note_ctr;
    logic [CNT_W-1:0]  n_act;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_lim;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
  } voa_ctrl_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               best_valid;
    logic [SCORE_W-1:0] best_score;
    logic [IDX_W-1:0]   best_idx;
    logic [CNT_W-1:0]   matched;
  } voa_tok_t;

endpackage

// ===== design/voice_allocator_with_stealing_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator with stealing
// Polyphonic voice table with note-on allocation, voice stealing, note-off,
// sustain pedal and panic handling, built as a chain of voice cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Word
//  in        input      in_valid_i / in_ready_o  voa_in_t event
//  out       output     out_valid_o / out_ready_i voa_out_t result
//  cfg       input      cfg_we_i (no wait)       5-bit voice count
//
// After acceptance the scan token walks the chain of MAX_VOICES voice cells,
// one register per cell, then the scan outcome is captured, and then the
// result moves into the output register, where the result word appears.
// The next event is accepted only once the result has moved into the
// output register, so events in the allocator never overlap.
// Reset clears every voice to free, the note counter and the pedal, and sets
// the voice count to eight. A stalled output word only delays the next event.
// ----------------------------------------------------------------------------
`include "voice_allocator_with_stealing_core_assert.svh"

module voice_allocator_with_stealing_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  voa_pkg::voa_in_t          in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output voa_pkg::voa_out_t         out_word_o,
  input  logic                      cfg_we_i,
  input  logic [voa_pkg::CNT_W-1:0] cfg_wdata_i
);

  // The controller idles, lets the token run through the cells, then stages
  // the result until the output register is free.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                          state_q;
  voa_pkg::voa_in_t                item_q;
  logic                            start_q;
  logic                            pedal_q;
  logic [voa_pkg::NOTE_W-1:0]      note_ctr_q;
  logic [voa_pkg::CNT_W-1:0]       voice_count_q;
  voa_pkg::voa_out_t               res_q;
  voa_pkg::voa_out_t               res_d;
  voa_pkg::voa_out_t               out_word_q;
  logic                            out_valid_q;

  logic [voa_pkg::CNT_W-1:0]       n_act;
  logic [voa_pkg::CNT_W-1:0]       cfg_lim;
  voa_pkg::voa_ctrl_t              ctrl;
  voa_pkg::voa_tok_t               tok [voa_pkg::MAX_VOICES+1];
  voa_pkg::voa_tok_t               last_tok;
  logic [voa_pkg::MAX_VOICES-1:0]  tok_vld;
  logic                            scan_done;
  logic                            is_note_on;

  // Counts above the table size behave as the table size.
  assign n_act = (voice_count_q > voa_pkg::CNT_W'(voa_pkg::MAX_VOICES)) ?
                 voa_pkg::CNT_W'(voa_pkg::MAX_VOICES) : voice_count_q;
  assign cfg_lim = (cfg_wdata_i > voa_pkg::CNT_W'(voa_pkg::MAX_VOICES)) ?
                   voa_pkg::CNT_W'(voa_pkg::MAX_VOICES) : cfg_wdata_i;

  assign last_tok   = tok[voa_pkg::MAX_VOICES];
  assign scan_done  = (state_q == ST_SCAN) && last_tok.valid;
  assign is_note_on = item_q.opcode == voa_pkg::OP_NOTE_ON;

  // Outcome of the scan. A note on prefers the lowest free voice; failing
  // that, it takes the best stealing candidate. With no voices enabled both
  // flags stay clear and nothing is granted.
  always_comb begin
    res_d                = '0;
    res_d.matched_voices = last_tok.matched;
    if (is_note_on) begin
      if (last_tok.free_found) begin
        res_d.chosen_voice = voa_pkg::CHOSEN_W'(last_tok.free_idx);
        res_d.granted      = 1'b1;
      end else if (last_tok.best_valid) begin
        res_d.chosen_voice = voa_pkg::CHOSEN_W'(last_tok.best_idx);
        res_d.granted      = 1'b1;
        res_d.was_stolen   = 1'b1;
      end
    end
  end

  // Broadcast to the cells. The winning voice is written in the same cycle as
  // the token leaves the last cell, when no cell is still updating it.
  always_comb begin
    ctrl            = '0;
    ctrl.op         = item_q.opcode;
    ctrl.key        = item_q.note_key;
    ctrl.fin        = item_q.finished_voice;
    ctrl.pedal_down = pedal_q;
    ctrl.note_ctr   = note_ctr_q;
    ctrl.n_act      = n_act;
    ctrl.cfg_we     = cfg_we_i;
    ctrl.cfg_lim    = cfg_lim;
    ctrl.wr_en      = scan_done && res_d.granted;
    ctrl.wr_idx     = voa_pkg::IDX_W'(res_d.chosen_voice);
  end

  // The token enters the first cell fresh for every event.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_q;
  end

  for (genvar g = 0; g < voa_pkg::MAX_VOICES; g++) begin : g_cell
    voa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (voa_pkg::IDX_W'(g)),
      .ctrl_i (ctrl),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      item_q        <= '0;
      start_q       <= 1'b0;
      pedal_q       <= 1'b0;
      note_ctr_q    <= '0;
      voice_count_q <= voa_pkg::CNT_W'(8);
      res_q         <= '0;
      out_word_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        voice_count_q <= cfg_wdata_i;
      end
      // While flushing, the staged word refills the output register instead.
      if (out_valid_q && out_ready_i && state_q != ST_FLUSH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_word_i;
            start_q <= 1'b1;
            state_q <= ST_SCAN;
            // The pedal changes before the scan so that the cells see the
            // new position when they release sustained voices.
            if (in_word_i.opcode == voa_pkg::OP_SUSTAIN) begin
              pedal_q <= in_word_i.pedal_value >= voa_pkg::PEDAL_DOWN_MIN;
            end else if (in_word_i.opcode == voa_pkg::OP_ALL_NOTES_OFF) begin
              pedal_q <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (last_tok.valid) begin
            res_q   <= res_d;
            state_q <= ST_FLUSH;
            if (res_d.granted) begin
              note_ctr_q <= note_ctr_q + voa_pkg::NOTE_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_word_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Only one scan token may be in the chain at a time.
  `VOA_ASSERT_ALWAYS(a_one_token, clk_i, rst_ni, $onehot0(tok_vld))
  // The token only leaves the chain while the controller waits for it.
  `VOA_ASSERT_IMP(a_token_in_scan, clk_i, rst_ni, last_tok.valid, state_q == ST_SCAN)
  // A stolen voice is always a granted one.
  `VOA_ASSERT_IMP(a_stolen_granted, clk_i, rst_ni,
                  out_valid_o && out_word_o.was_stolen, out_word_o.granted)

endmodule

// ===== design/voa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice cell
// Holds one voice and updates it as the scan token passes, folding its own
// free-voice and stealing candidates into the token.
// ----------------------------------------------------------------------------
module voa_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [voa_pkg::IDX_W-1:0]     idx_i,
  input  voa_pkg::voa_ctrl_t            ctrl_i,
  input  voa_pkg::voa_tok_t             tok_i,
  output voa_pkg::voa_tok_t             tok_o
);

  voa_pkg::voa_status_e               status_q;
  voa_pkg::voa_status_e               status_d;
  logic [voa_pkg::KEY_W-1:0]          key_q;
  logic [voa_pkg::NOTE_W-1:0]         num_q;
  voa_pkg::voa_tok_t                  tok_q;
  voa_pkg::voa_tok_t                  tok_d;
  logic                               active;
  logic                               key_hit;
  logic                               wr_hit;
  logic                               cfg_free;
  logic [voa_pkg::NOTE_W-1:0]         age;
  logic [voa_pkg::SCORE_W-1:0]        bonus;
  logic [voa_pkg::SCORE_W-1:0]        score;

  assign active   = voa_pkg::CNT_W'(idx_i) < ctrl_i.n_act;
  assign key_hit  = key_q == ctrl_i.key;
  assign wr_hit   = ctrl_i.wr_en && (ctrl_i.wr_idx == idx_i);
  assign cfg_free = ctrl_i.cfg_we && (voa_pkg::CNT_W'(idx_i) >= ctrl_i.cfg_lim);

  always_comb begin
    status_d = status_q;
    tok_d    = tok_i;
    unique case (ctrl_i.op)
      voa_pkg::OP_NOTE_ON: begin
        if (active && key_hit &&
            (status_q == voa_pkg::ST_HELD || status_q == voa_pkg::ST_SUST)) begin
          status_d = voa_pkg::ST_REL;
        end
      end
      voa_pkg::OP_NOTE_OFF: begin
        if (active && key_hit && status_q == voa_pkg::ST_HELD) begin
          status_d      = ctrl_i.pedal_down ? voa_pkg::ST_SUST : voa_pkg::ST_REL;
          tok_d.matched = tok_i.matched + voa_pkg::CNT_W'(1);
        end
      end
      voa_pkg::OP_SUSTAIN: begin
        if (active && !ctrl_i.pedal_down && status_q == voa_pkg::ST_SUST) begin
          status_d = voa_pkg::ST_REL;
        end
      end
      voa_pkg::OP_ALL_NOTES_OFF: begin
        if (active &&
            (status_q == voa_pkg::ST_HELD || status_q == voa_pkg::ST_SUST)) begin
          status_d = voa_pkg::ST_REL;
        end
      end
      voa_pkg::OP_ALL_SOUNDS_OFF: begin
        if (active) begin
          status_d = voa_pkg::ST_FREE;
        end
      end
      voa_pkg::OP_VOICE_FINISHED: begin
        if (voa_pkg::CNT_W'(idx_i) == voa_pkg::CNT_W'(ctrl_i.fin)) begin
          status_d = voa_pkg::ST_FREE;
        end
      end
      default: begin
      end
    endcase

    // Released voices get the larger bonus on top of their age, sustained ones
    // a smaller one; an older voice scores higher, and the highest score is stolen.
    age = ctrl_i.note_ctr - num_q;
    case (status_d)
      voa_pkg::ST_REL:  bonus = voa_pkg::REL_BONUS;
      voa_pkg::ST_SUST: bonus = voa_pkg::SUST_BONUS;
      default:          bonus = '0;
    endcase
    score = {1'b0, age} + bonus;

    if (ctrl_i.op == voa_pkg::OP_NOTE_ON && active) begin
      if (!tok_i.free_found && status_d == voa_pkg::ST_FREE) begin
        tok_d.free_found = 1'b1;
        tok_d.free_idx   = idx_i;
      end
      if (!tok_i.best_valid || score > tok_i.best_score) begin
        tok_d.best_valid = 1'b1;
        tok_d.best_score = score;
        tok_d.best_idx   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= voa_pkg::ST_FREE;
      tok_q    <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_hit) begin
        status_q <= voa_pkg::ST_HELD;
      end else if (cfg_free) begin
        status_q <= voa_pkg::ST_FREE;
      end else if (tok_i.valid) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      num_q <= '0;
    end else if (wr_hit) begin
      key_q <= ctrl_i.key;
      num_q <= ctrl_i.note_ctr;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives MIDI-style event words into the voice allocator and checks every
// result word against a typed row or the behavioural table copy. A short table of
// directed events comes first, then randomised phases at several voice counts.
// Both handshakes idle at random, and the output side holds off for long
// stretches so that the allocator fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;

  // Opcodes the allocator must treat as no-ops.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Stealing weights: the voice with the lowest score is taken.
  localparam int STEAL_BASE = 10000;
  localparam int STEAL_CEIL = 10001;
  localparam int REL_DROP   = 2000;
  localparam int SUST_DROP  = 1000;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_NS     = 6_000_000;

  localparam logic [voa_pkg::CNT_W-1:0] PHASE_COUNT [PHASES] =
    '{5'd16, 5'd4, 5'd1, 5'd31, 5'd7, 5'd20};

  typedef enum logic [1:0] {
    ROW_EVENT,  // result worked out by the voice table copy
    ROW_TYPED,  // result typed into the row
    ROW_CONFIG  // voice count write
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    voa_pkg::voa_in_t          ev;
    voa_pkg::voa_out_t         want;
    logic [voa_pkg::CNT_W-1:0] count;
  } dir_row_t;

  localparam voa_pkg::voa_out_t ZERO_RES = '0;
  localparam voa_pkg::voa_in_t  NO_EVENT = '0;
  localparam int DIR_ROWS = 32;

  // The directed walk. Typed rows are those whose result is obvious from the
  // voice table at that point; the rest go through the behavioural copy.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Nothing is held after reset, so a note off matches no voice.
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_OFF, 7'd0, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd127, 7'd0, 4'd0},
      '{4'd0, 1'b0, 1'b1, 5'd0}, 5'd0},
    // Same key again: voice 0 is released first, so voice 1 is the lowest free one.
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd127, 7'd127, 4'd15},
      '{4'd1, 1'b0, 1'b1, 5'd0}, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_OFF, 7'd127, 7'd0, 4'd0},
      '{4'd0, 1'b0, 1'b0, 5'd1}, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_SUSTAIN, 7'd0, 7'd127, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_ON, 7'h55, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_ON, 7'h2a, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // Pedal is down, so this note off sustains rather than releases.
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_OFF, 7'h55, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // Just below the pedal threshold: pedal up, sustained voices released.
    '{ROW_TYPED, '{voa_pkg::OP_SUSTAIN, 7'd0, 7'd63, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{OP_SPARE_7, 7'd127, 7'd127, 4'd15}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{OP_SPARE_6, 7'd0, 7'd64, 4'd0}, ZERO_RES, 5'd0},
    // Exactly at the threshold counts as pedal down.
    '{ROW_TYPED, '{voa_pkg::OP_SUSTAIN, 7'd0, 7'd64, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_OFF, 7'h2a, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_ALL_NOTES_OFF, 7'd0, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // A finished voice beyond the voice count is still freed.
    '{ROW_TYPED, '{voa_pkg::OP_VOICE_FINISHED, 7'd0, 7'd0, 4'd15}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_VOICE_FINISHED, 7'd0, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // Shrinking to two voices frees everything above them.
    '{ROW_CONFIG, NO_EVENT, ZERO_RES, 5'd2},
    '{ROW_TYPED, '{voa_pkg::OP_ALL_SOUNDS_OFF, 7'd0, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd1, 7'd0, 4'd0},
      '{4'd0, 1'b0, 1'b1, 5'd0}, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd2, 7'd0, 4'd0},
      '{4'd1, 1'b0, 1'b1, 5'd0}, 5'd0},
    // Both voices held: the older one is stolen.
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_ON, 7'd3, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_OFF, 7'd2, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // With no voices at all a note on is refused.
    '{ROW_CONFIG, NO_EVENT, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd64, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_OFF, 7'd1, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    // Counts above the table size act as the full table.
    '{ROW_CONFIG, NO_EVENT, ZERO_RES, 5'd31},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd0, 7'd0, 4'd0},
      '{4'd0, 1'b0, 1'b1, 5'd0}, 5'd0},
    // A single voice, still held from the last note on: every note on steals it.
    '{ROW_CONFIG, NO_EVENT, ZERO_RES, 5'd1},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd9, 7'd0, 4'd0},
      '{4'd0, 1'b1, 1'b1, 5'd0}, 5'd0},
    '{ROW_TYPED, '{voa_pkg::OP_NOTE_ON, 7'd10, 7'd0, 4'd0},
      '{4'd0, 1'b1, 1'b1, 5'd0}, 5'd0},
    '{ROW_EVENT, '{voa_pkg::OP_NOTE_ON, 7'd10, 7'd0, 4'd0}, ZERO_RES, 5'd0},
    '{ROW_CONFIG, NO_EVENT, ZERO_RES, 5'd16}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  voa_pkg::voa_in_t          in_word_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  voa_pkg::voa_out_t         out_word_o;
  logic                      cfg_we_i;
  logic [voa_pkg::CNT_W-1:0] cfg_wdata_i;

  voice_allocator_with_stealing_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioural copy of the voice table, kept in step with accepted words.
  voa_pkg::voa_status_e       vs_status  [voa_pkg::MAX_VOICES];
  logic [voa_pkg::KEY_W-1:0]  vs_key     [voa_pkg::MAX_VOICES];
  logic [voa_pkg::NOTE_W-1:0] vs_started [voa_pkg::MAX_VOICES];
  logic [voa_pkg::NOTE_W-1:0] notes_started;
  logic                       sustain_held;
  logic [voa_pkg::CNT_W-1:0]  voices_enabled;

  // Result words still awaited from the allocator, oldest first.
  voa_pkg::voa_out_t outcome_fifo [$];

  logic [voa_pkg::KEY_W-1:0] key_pool [8];
  bit calm;
  bit hold_req;

  int mismatch_count;
  int outcomes_checked;
  int events_sent;
  int count_writes;
  int grants_seen;
  int steals_seen;
  int long_holds;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch at result word %0d: %s", $time, outcomes_checked, what);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic int live_voices();
    return (voices_enabled > voa_pkg::MAX_VOICES) ? voa_pkg::MAX_VOICES
                                                  : int'(voices_enabled);
  endfunction

  function automatic void resize_voice_table(input logic [voa_pkg::CNT_W-1:0] value);
    voices_enabled = value;
    for (int i = live_voices(); i < voa_pkg::MAX_VOICES; i++)
      vs_status[i] = voa_pkg::ST_FREE;
  endfunction

  // Applies one event to the voice table copy and returns its result word.
  function automatic voa_pkg::voa_out_t apply_midi_event(input voa_pkg::voa_in_t w);
    voa_pkg::voa_out_t res;
    int n;
    int pick;
    int best;
    int score;
    bit found;
    logic [voa_pkg::NOTE_W-1:0] age;
    res   = '0;
    n     = live_voices();
    pick  = 0;
    found = 1'b0;
    case (w.opcode)
      voa_pkg::OP_NOTE_ON: begin
        for (int i = 0; i < n; i++)
          if (vs_key[i] == w.note_key &&
              (vs_status[i] == voa_pkg::ST_HELD || vs_status[i] == voa_pkg::ST_SUST))
            vs_status[i] = voa_pkg::ST_REL;
        for (int i = 0; i < n; i++)
          if (!found && vs_status[i] == voa_pkg::ST_FREE) begin
            pick  = i;
            found = 1'b1;
          end
        if (!found && n > 0) begin
          best = STEAL_CEIL;
          for (int i = 0; i < n; i++) begin
            age   = notes_started - vs_started[i];
            score = STEAL_BASE - int'(age);
            if (vs_status[i] == voa_pkg::ST_REL) score -= REL_DROP;
            else if (vs_status[i] == voa_pkg::ST_SUST) score -= SUST_DROP;
            if (score < best) begin
              best  = score;
              pick  = i;
              found = 1'b1;
            end
          end
          res.was_stolen = found;
          if (found) steals_seen++;
        end
        if (found) begin
          res.granted      = 1'b1;
          res.chosen_voice = pick[voa_pkg::CHOSEN_W-1:0];
          vs_status[pick]  = voa_pkg::ST_HELD;
          vs_key[pick]     = w.note_key;
          vs_started[pick] = notes_started;
          notes_started    = notes_started + 1'b1;
          grants_seen++;
        end
      end
      voa_pkg::OP_NOTE_OFF: begin
        for (int i = 0; i < n; i++)
          if (vs_status[i] == voa_pkg::ST_HELD && vs_key[i] == w.note_key) begin
            vs_status[i] = sustain_held ? voa_pkg::ST_SUST : voa_pkg::ST_REL;
            res.matched_voices = res.matched_voices + 1'b1;
          end
      end
      voa_pkg::OP_SUSTAIN: begin
        sustain_held = (w.pedal_value >= voa_pkg::PEDAL_DOWN_MIN);
        if (!sustain_held)
          for (int i = 0; i < n; i++)
            if (vs_status[i] == voa_pkg::ST_SUST) vs_status[i] = voa_pkg::ST_REL;
      end
      voa_pkg::OP_ALL_NOTES_OFF: begin
        sustain_held = 1'b0;
        for (int i = 0; i < n; i++)
          if (vs_status[i] == voa_pkg::ST_HELD || vs_status[i] == voa_pkg::ST_SUST)
            vs_status[i] = voa_pkg::ST_REL;
      end
      voa_pkg::OP_ALL_SOUNDS_OFF: begin
        for (int i = 0; i < n; i++) vs_status[i] = voa_pkg::ST_FREE;
      end
      voa_pkg::OP_VOICE_FINISHED: begin
        vs_status[w.finished_voice] = voa_pkg::ST_FREE;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random event, weighted towards note on and note off on a small pool of
  // keys so that voices fill up, get released, sustained and stolen.
  function automatic voa_pkg::voa_in_t random_event();
    voa_pkg::voa_in_t w;
    int r;
    int n;
    n = live_voices();
    w.note_key       = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)]
                                                  : voa_pkg::KEY_W'($urandom_range(0, 127));
    w.pedal_value    = voa_pkg::KEY_W'($urandom_range(0, 127));
    w.finished_voice = (n > 0 && $urandom_range(0, 3) != 0) ? 4'($urandom_range(0, n - 1))
                                                           : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 42)      w.opcode = voa_pkg::OP_NOTE_ON;
    else if (r < 68) w.opcode = voa_pkg::OP_NOTE_OFF;
    else if (r < 78) w.opcode = voa_pkg::OP_SUSTAIN;
    else if (r < 91) w.opcode = voa_pkg::OP_VOICE_FINISHED;
    else if (r < 94) w.opcode = voa_pkg::OP_ALL_NOTES_OFF;
    else if (r < 97) w.opcode = voa_pkg::OP_ALL_SOUNDS_OFF;
    else if (r < 99) w.opcode = OP_SPARE_6;
    else             w.opcode = OP_SPARE_7;
    return w;
  endfunction

  // Offers one event word after a random gap and holds it until accepted.
  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic offer_event(input voa_pkg::voa_in_t w, input bit typed,
                             input voa_pkg::voa_out_t typed_res);
    int gap;
    voa_pkg::voa_out_t predicted;
    gap = idle_len();
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_midi_event(w);
    outcome_fifo.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  // The voice count is only written with nothing in flight. Every event
  // yields a result word, so an empty queue means the allocator is idle.
  // The write enable is left high; the next event offer lowers it.
  task automatic write_voice_count(input logic [voa_pkg::CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    resize_voice_table(value);
    count_writes++;
  endtask

  // Output side: random stalls, plus a long hold-off whenever one is asked
  // for, so that the result register stays full and the input backs up.
  initial begin : output_side
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if (hold_req) begin
          hold_req = 1'b0;
          long_holds++;
          stall_left = HOLD_CYCLES - 1;
          out_ready_i <= 1'b0;
        end else begin
          if ($urandom_range(0, 3) == 0) stall_left = idle_len();
          out_ready_i <= (stall_left == 0);
          if (stall_left > 0) stall_left--;
        end
      end
    end
  end

  // Every accepted result word is compared with the oldest one awaited.
  always @(posedge clk_i) begin : result_check
    voa_pkg::voa_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_fifo.size() == 0) begin
        report_mismatch($sformatf("result word %h arrived with none awaited", out_word_o));
      end else begin
        want = outcome_fifo.pop_front();
        if (out_word_o.chosen_voice !== want.chosen_voice)
          report_mismatch($sformatf("chosen_voice %0d, expected %0d",
                                    out_word_o.chosen_voice, want.chosen_voice));
        if (out_word_o.was_stolen !== want.was_stolen)
          report_mismatch($sformatf("was_stolen %b, expected %b",
                                    out_word_o.was_stolen, want.was_stolen));
        if (out_word_o.granted !== want.granted)
          report_mismatch($sformatf("granted %b, expected %b",
                                    out_word_o.granted, want.granted));
        if (out_word_o.matched_voices !== want.matched_voices)
          report_mismatch($sformatf("matched_voices %0d, expected %0d",
                                    out_word_o.matched_voices, want.matched_voices));
        outcomes_checked++;
      end
    end
  end

  initial begin : stimulus
    voa_pkg::voa_in_t w;
    int counted;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < voa_pkg::MAX_VOICES; i++) begin
      vs_status[i]  = voa_pkg::ST_FREE;
      vs_key[i]     = '0;
      vs_started[i] = '0;
    end
    notes_started  = '0;
    sustain_held   = 1'b0;
    voices_enabled = 5'd8;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      case (DIRECTED[r].kind)
        ROW_CONFIG: write_voice_count(DIRECTED[r].count);
        ROW_TYPED:  offer_event(DIRECTED[r].ev, 1'b1, DIRECTED[r].want);
        default:    offer_event(DIRECTED[r].ev, 1'b0, ZERO_RES);
      endcase
    end

    // Random phases, each at its own voice count. Two run with no idling at
    // all, and two open with a long output hold-off.
    for (int p = 0; p < PHASES; p++) begin
      write_voice_count(PHASE_COUNT[p]);
      calm = (p == 2 || p == 4);
      foreach (key_pool[k]) key_pool[k] = voa_pkg::KEY_W'($urandom_range(0, 127));
      if (p == 0) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      if (p == 0 || p == 3) hold_req = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        w = random_event();
        offer_event(w, 1'b0, ZERO_RES);
        if (w.opcode != OP_SPARE_6 && w.opcode != OP_SPARE_7) counted++;
      end
    end
    in_valid_i <= 1'b0;

    while (outcome_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words from %0d events across %0d voice count writes.",
             outcomes_checked, events_sent, count_writes);
    $display("Voices granted %0d times, %0d of them stolen; %0d long output hold-offs.",
             grants_seen, steals_seen, long_holds);
    if (mismatch_count == 0 && outcome_fifo.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

endmodule

// ===== voice_allocator_with_stealing_core.f =====
+incdir+design
design/voa_pkg.sv
design/voa_cell.sv
design/voice_allocator_with_stealing_core.sv
tb/tb.sv
